>>> rtl/rti_pkg.sv
// Shared constants and types for the ray/triangle intersection pipeline.
// No dependencies; used by ray_triangle_intersection.
`default_nettype none

package rti_pkg;

    localparam int COORD_W   = 32;              // coordinate width, signed Q16.16
    localparam int FRAC_W    = 16;              // fraction bits
    localparam int TOL_W     = COORD_W - 1;     // tolerance register width
    localparam int DIFF_W    = COORD_W + 1;     // edge and offset vectors
    localparam int PROD_W    = 2 * DIFF_W;      // cross product partial terms
    localparam int CROSS_W   = PROD_W + 1;      // cross product components
    localparam int SPLIT_W   = 34;              // low slice of a cross component
    localparam int PLO_W     = SPLIT_W + 1 + DIFF_W;
    localparam int PHI_W     = (CROSS_W - SPLIT_W) + DIFF_W;
    localparam int DOT_W     = 101;             // determinants, signed
    localparam int Q_W       = 31;              // distance width
    localparam int REM_W     = DOT_W + Q_W;     // division remainder
    localparam int DIV_STEPS = Q_W;             // one quotient bit per stage
    localparam int FRONT_STAGES = 8;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS;
    localparam int IN_W      = 9 * COORD_W;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [Q_W-1:0] DIST_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_ORIGIN_Z    = 3'd2,
        REG_DIRECTION_X = 3'd3,
        REG_DIRECTION_Y = 3'd4,
        REG_DIRECTION_Z = 3'd5,
        REG_TOLERANCE   = 3'd6
    } cfg_reg_t;

    // One stage of the restoring divider, with the verdict riding along.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DOT_W-1:0] den;
        logic [Q_W-1:0]   quo;
        logic             miss;
        logic             sat;
    } div_stage_t;

endpackage

`default_nettype wire

>>> rtl/ray_triangle_intersection.sv
// Top level of the ray/triangle intersection pipeline (Moller-Trumbore, exact fixed point).
// Depends on rti_pkg.
//
// Usage: the ray (origin, direction) and the tolerance are written through the
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while the block
// is idle; cfg_ready is always high and an index beyond the register list is ignored.
// Triangles enter on the s_axis channel, one transaction per triangle, with the nine
// vertex coordinates in tdata. Each triangle yields exactly one result transaction on
// m_axis: tuser carries the hit flag and tdata the saturated Q16.16 distance, which is
// zero on a miss.
//
// Throughput is one triangle per cycle while the pipeline is not stalled. There are
// forty register stages: eight of edge, cross product, dot product and test logic,
// then a 31-stage restoring divider that produces one quotient bit per stage, then
// the output register. The first stage loads at the accepting edge; each triangle
// then moves through the stages in order. The divider chain sets the latency.
//
// Reset clears all valid bits and restores the register defaults (origin at zero,
// direction +z, tolerance one LSB). When the receiver stalls, the result holds in the
// output register; the pipeline keeps advancing while its last stage is empty, and
// stops as a whole (s_axis_tready low) once a second result is waiting behind it.
`default_nettype none

module ray_triangle_intersection (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Configuration write channel.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rti_pkg::COORD_W-1:0] cfg_data,
    // Triangle input stream.
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata, lowest bits first: first_x, first_y, first_z, second_x, second_y,
    // second_z, third_x, third_y, third_z (32 bits each).
    input  wire logic [rti_pkg::IN_W-1:0]    s_axis_tdata,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // tdata, lowest bits first: distance (31 bits), one zero pad bit.
    output logic [rti_pkg::OUT_W-1:0]        m_axis_tdata,
    // tuser: hit.
    output logic                             m_axis_tuser
);

    localparam int CW  = rti_pkg::COORD_W;
    localparam int FW  = rti_pkg::FRAC_W;
    localparam int TW  = rti_pkg::TOL_W;
    localparam int DW  = rti_pkg::DIFF_W;
    localparam int PW  = rti_pkg::PROD_W;
    localparam int XW  = rti_pkg::CROSS_W;
    localparam int SW  = rti_pkg::SPLIT_W;
    localparam int LW  = rti_pkg::PLO_W;
    localparam int HW  = rti_pkg::PHI_W;
    localparam int TTW = rti_pkg::DOT_W;
    localparam int SUW = rti_pkg::DOT_W + 1;
    localparam int RW  = rti_pkg::REM_W;
    localparam int QW  = rti_pkg::Q_W;
    localparam int NS  = rti_pkg::NUM_STAGES;
    localparam int NDIV = rti_pkg::DIV_STEPS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [CW-1:0] origin_reg [3];
    logic signed [CW-1:0] dir_reg    [3];
    logic        [TW-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= CW'(1) << FW;
            tol_reg       <= TW'(1);
        end
        else if (cfg_valid)
        begin
            case (rti_pkg::cfg_reg_t'(cfg_index))
                rti_pkg::REG_ORIGIN_X:    origin_reg[0] <= cfg_data;
                rti_pkg::REG_ORIGIN_Y:    origin_reg[1] <= cfg_data;
                rti_pkg::REG_ORIGIN_Z:    origin_reg[2] <= cfg_data;
                rti_pkg::REG_DIRECTION_X: dir_reg[0]    <= cfg_data;
                rti_pkg::REG_DIRECTION_Y: dir_reg[1]    <= cfg_data;
                rti_pkg::REG_DIRECTION_Z: dir_reg[2]    <= cfg_data;
                rti_pkg::REG_TOLERANCE:   tol_reg       <= cfg_data[TW-1:0];
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves as one, unless its last stage is
    // empty, in which case it may advance under a waiting result.
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic          out_valid_reg;
    logic          out_free;
    logic          pipe_en;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign pipe_en       = !valid_reg[NS-1] || out_free;
    assign s_axis_tready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pipe_en)
            begin
                valid_reg <= {valid_reg[NS-2:0], s_axis_tvalid};
            end
            if (out_free)
            begin
                out_valid_reg <= valid_reg[NS-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: edges e1, e2, origin offset o and negated direction.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] vin [9];
    logic signed [DW-1:0] e1_next [3], e2_next [3], o_next [3], nd_next [3];
    logic signed [DW-1:0] st1_e1_reg [3], st1_e2_reg [3], st1_o_reg [3], st1_nd_reg [3];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            vin[i] = s_axis_tdata[CW*i +: CW];
        end
        for (int k = 0; k < 3; k++)
        begin
            e1_next[k] = DW'(vin[3+k]) - DW'(vin[k]);
            e2_next[k] = DW'(vin[6+k]) - DW'(vin[k]);
            o_next[k]  = DW'(origin_reg[k]) - DW'(vin[k]);
            nd_next[k] = -(DW'(dir_reg[k]));
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products for c = e1 x e2 and s = nd x o.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] cp_next [12];
    logic signed [PW-1:0] st2_cp_reg [12];
    logic signed [DW-1:0] st2_e1_reg [3], st2_e2_reg [3], st2_o_reg [3], st2_nd_reg [3];

    always_comb
    begin
        cp_next[0]  = st1_e1_reg[1] * st1_e2_reg[2];
        cp_next[1]  = st1_e1_reg[2] * st1_e2_reg[1];
        cp_next[2]  = st1_e1_reg[2] * st1_e2_reg[0];
        cp_next[3]  = st1_e1_reg[0] * st1_e2_reg[2];
        cp_next[4]  = st1_e1_reg[0] * st1_e2_reg[1];
        cp_next[5]  = st1_e1_reg[1] * st1_e2_reg[0];
        cp_next[6]  = st1_nd_reg[1] * st1_o_reg[2];
        cp_next[7]  = st1_nd_reg[2] * st1_o_reg[1];
        cp_next[8]  = st1_nd_reg[2] * st1_o_reg[0];
        cp_next[9]  = st1_nd_reg[0] * st1_o_reg[2];
        cp_next[10] = st1_nd_reg[0] * st1_o_reg[1];
        cp_next[11] = st1_nd_reg[1] * st1_o_reg[0];
    end

    // ------------------------------------------------------------------
    // Stage 3: cross product components.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cr_next [6];
    logic signed [XW-1:0] st3_cr_reg [6];
    logic signed [DW-1:0] st3_e1_reg [3], st3_e2_reg [3], st3_o_reg [3], st3_nd_reg [3];

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            cr_next[k] = XW'(st2_cp_reg[2*k]) - XW'(st2_cp_reg[2*k+1]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: dot product partial products. Each cross component is split
    // into an unsigned low slice and a signed high slice.
    //   d = nd.c, nt = o.c, nu = s.e2, nv = -(s.e1)
    // ------------------------------------------------------------------
    logic signed [XW-1:0] dot_a [12];
    logic signed [DW-1:0] dot_b [12];
    logic signed [LW-1:0] plo_next [12];
    logic signed [HW-1:0] phi_next [12];
    logic signed [LW-1:0] st4_plo_reg [12];
    logic signed [HW-1:0] st4_phi_reg [12];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dot_a[k]   = st3_cr_reg[k];
            dot_b[k]   = st3_nd_reg[k];
            dot_a[3+k] = st3_cr_reg[k];
            dot_b[3+k] = st3_o_reg[k];
            dot_a[6+k] = st3_cr_reg[3+k];
            dot_b[6+k] = st3_e2_reg[k];
            dot_a[9+k] = st3_cr_reg[3+k];
            dot_b[9+k] = st3_e1_reg[k];
        end
        for (int j = 0; j < 12; j++)
        begin
            plo_next[j] = $signed({1'b0, dot_a[j][SW-1:0]}) * dot_b[j];
            phi_next[j] = $signed(dot_a[j][XW-1:SW]) * dot_b[j];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine the slices into full products.
    // ------------------------------------------------------------------
    logic signed [TTW-1:0] term_next [12];
    logic signed [TTW-1:0] st5_term_reg [12];

    always_comb
    begin
        for (int j = 0; j < 12; j++)
        begin
            term_next[j] = (TTW'(st4_phi_reg[j]) <<< SW) + TTW'(st4_plo_reg[j]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: the four determinants.
    // ------------------------------------------------------------------
    logic signed [TTW-1:0] det_next [4];
    logic signed [TTW-1:0] st6_det_reg [4];

    always_comb
    begin
        for (int m = 0; m < 3; m++)
        begin
            det_next[m] = st5_term_reg[3*m] + st5_term_reg[3*m+1] + st5_term_reg[3*m+2];
        end
        det_next[3] = -(st5_term_reg[9] + st5_term_reg[10] + st5_term_reg[11]);
    end

    // ------------------------------------------------------------------
    // Stage 7: make the denominator positive; note a zero determinant.
    // Order in the det arrays: d, nt, nu, nv.
    // ------------------------------------------------------------------
    logic signed [TTW-1:0] norm_next [4];
    logic                  zero_next;
    logic signed [TTW-1:0] st7_det_reg [4];
    logic                  st7_zero_reg;

    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            norm_next[m] = st6_det_reg[0][TTW-1] ? -st6_det_reg[m] : st6_det_reg[m];
        end
        zero_next = (st6_det_reg[0] == '0);
    end

    // ------------------------------------------------------------------
    // Stage 8: barycentric, parallelism and sign tests; set up the divider.
    // Distance below tolerance is judged on the quotient at the end, since
    // nt * 2^F < tol * d exactly when floor(nt * 2^F / d) < tol.
    // ------------------------------------------------------------------
    logic signed [SUW-1:0] uv_sum;
    logic signed [TTW-1:0] tol_scaled;
    logic        [RW-1:0]  rem_init;
    logic        [RW-1:0]  den_wide;
    rti_pkg::div_stage_t   div_first;

    always_comb
    begin
        uv_sum     = SUW'(st7_det_reg[2]) + SUW'(st7_det_reg[3]);
        tol_scaled = $signed({{(TTW - TW - 2*FW){1'b0}}, tol_reg, {(2*FW){1'b0}}});
        rem_init   = st7_det_reg[1][TTW-1] ? '0 :
                     ({{(RW - TTW){1'b0}}, st7_det_reg[1]} << FW);
        den_wide   = {{(RW - TTW){1'b0}}, st7_det_reg[0]};

        div_first.rem  = rem_init;
        div_first.den  = st7_det_reg[0];
        div_first.quo  = '0;
        div_first.sat  = (rem_init >= (den_wide << QW));
        div_first.miss = st7_zero_reg
                      || st7_det_reg[2][TTW-1] || (st7_det_reg[2] > st7_det_reg[0])
                      || st7_det_reg[3][TTW-1] || (st7_det_reg[3] > st7_det_reg[0])
                      || (uv_sum > SUW'(st7_det_reg[0]))
                      || st7_det_reg[1][TTW-1]
                      || (st7_det_reg[0] < tol_scaled);
    end

    // ------------------------------------------------------------------
    // Divider: stage j resolves quotient bit QW-1-j.
    // ------------------------------------------------------------------
    rti_pkg::div_stage_t div_reg  [NDIV+1];
    rti_pkg::div_stage_t div_next [NDIV];
    logic [RW-1:0]       div_shift [NDIV];

    always_comb
    begin
        for (int j = 0; j < NDIV; j++)
        begin
            div_next[j]  = div_reg[j];
            div_shift[j] = {{(RW - TTW){1'b0}}, div_reg[j].den} << (QW - 1 - j);
            if (div_shift[j] <= div_reg[j].rem)
            begin
                div_next[j].rem = div_reg[j].rem - div_shift[j];
                div_next[j].quo = div_reg[j].quo | (QW'(1) << (QW - 1 - j));
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline data registers (no reset; qualified by valid_reg).
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                st1_e1_reg[k] <= e1_next[k];
                st1_e2_reg[k] <= e2_next[k];
                st1_o_reg[k]  <= o_next[k];
                st1_nd_reg[k] <= nd_next[k];
                st2_e1_reg[k] <= st1_e1_reg[k];
                st2_e2_reg[k] <= st1_e2_reg[k];
                st2_o_reg[k]  <= st1_o_reg[k];
                st2_nd_reg[k] <= st1_nd_reg[k];
                st3_e1_reg[k] <= st2_e1_reg[k];
                st3_e2_reg[k] <= st2_e2_reg[k];
                st3_o_reg[k]  <= st2_o_reg[k];
                st3_nd_reg[k] <= st2_nd_reg[k];
            end
            for (int j = 0; j < 12; j++)
            begin
                st2_cp_reg[j]   <= cp_next[j];
                st4_plo_reg[j]  <= plo_next[j];
                st4_phi_reg[j]  <= phi_next[j];
                st5_term_reg[j] <= term_next[j];
            end
            for (int k = 0; k < 6; k++)
            begin
                st3_cr_reg[k] <= cr_next[k];
            end
            for (int m = 0; m < 4; m++)
            begin
                st6_det_reg[m] <= det_next[m];
                st7_det_reg[m] <= norm_next[m];
            end
            st7_zero_reg <= zero_next;
            div_reg[0]   <= div_first;
            for (int j = 0; j < NDIV; j++)
            begin
                div_reg[j+1] <= div_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: final verdict, saturation and tolerance check.
    // ------------------------------------------------------------------
    logic [QW-1:0] quo_final;
    logic          hit_next;
    logic          hit_reg;
    logic [QW-1:0] dist_reg;

    assign quo_final = div_reg[NDIV].sat ? rti_pkg::DIST_MAX : div_reg[NDIV].quo;
    assign hit_next  = !div_reg[NDIV].miss && (quo_final >= tol_reg);

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            hit_reg  <= hit_next;
            dist_reg <= hit_next ? quo_final : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = hit_reg;
    assign m_axis_tdata  = {{(rti_pkg::OUT_W - QW){1'b0}}, dist_reg};

`ifndef SYNTHESIS
    // A held pipeline keeps its occupancy.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(valid_reg))
        else $error("pipeline occupancy changed while stalled");

    // Input backpressure only arises from a result waiting downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && valid_reg[NS-1]))
        else $error("input stalled without downstream backpressure");

    // An accepted triangle occupies the first stage next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted transaction lost at pipeline entry");

    // A finished item moves into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NS-1] && out_free) |=> m_axis_tvalid)
        else $error("finished item did not reach the output register");
`endif

endmodule

`default_nettype wire

>>> verif/rti_hit_checker.sv
// Checker for the ray/triangle intersection block: it tracks the ray registers,
// predicts the hit flag and distance of every accepted triangle, and compares results.
// Depends on rti_pkg.
`timescale 1ns / 1ps

module rti_hit_checker
    import rti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0] cfg_data,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [IN_W-1:0]    s_axis_tdata,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [OUT_W-1:0]   m_axis_tdata,
    input  logic               m_axis_tuser,
    output int                 fail_count,
    output int                 outstanding
);

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic           hit;
        logic [Q_W-1:0] distance;
    } verdict_t;

    logic [COORD_W-1:0] ray_org [3];
    logic [COORD_W-1:0] ray_dir [3];
    logic [TOL_W-1:0]   min_dist;
    verdict_t           pending_verdicts [$];
    int                 result_no;

    function automatic wide_t widen(input logic [COORD_W-1:0] v);
        return {{(192 - COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic wide_t det3(input wide_t a0, a1, a2, b0, b1, b2, c0, c1, c2);
        return a0 * b1 * c2 - a0 * b2 * c1 - a1 * b0 * c2
             + a1 * b2 * c0 + a2 * b0 * c1 - a2 * b1 * c0;
    endfunction

    // Exact Cramer's-rule intersection; every test is a comparison of integers.
    function automatic verdict_t intersect_ray(input logic [IN_W-1:0] tri_bits);
        wide_t    p0 [3];
        wide_t    e1 [3];
        wide_t    e2 [3];
        wide_t    ofs [3];
        wide_t    nd [3];
        wide_t    d, nu, nv, nt, rem, tol_w;
        verdict_t v;
        v.hit = 1'b0;
        v.distance = '0;
        for (int k = 0; k < 3; k++)
        begin
            p0[k]  = widen(tri_bits[COORD_W*k +: COORD_W]);
            e1[k]  = widen(tri_bits[COORD_W*(3+k) +: COORD_W]) - p0[k];
            e2[k]  = widen(tri_bits[COORD_W*(6+k) +: COORD_W]) - p0[k];
            ofs[k] = widen(ray_org[k]) - p0[k];
            nd[k]  = -widen(ray_dir[k]);
        end
        d  = det3(nd[0], nd[1], nd[2], e1[0], e1[1], e1[2], e2[0], e2[1], e2[2]);
        nu = det3(nd[0], nd[1], nd[2], ofs[0], ofs[1], ofs[2], e2[0], e2[1], e2[2]);
        nv = det3(nd[0], nd[1], nd[2], e1[0], e1[1], e1[2], ofs[0], ofs[1], ofs[2]);
        nt = det3(ofs[0], ofs[1], ofs[2], e1[0], e1[1], e1[2], e2[0], e2[1], e2[2]);
        if (d == 0)
            return v;
        // Flip signs so the tests act on the true quotients.
        if (d < 0)
        begin
            d = -d;
            nu = -nu;
            nv = -nv;
            nt = -nt;
        end
        tol_w = {161'b0, min_dist};
        rem = nt <<< FRAC_W;
        if (nu < 0 || nu > d || nv < 0 || nv > d || nu + nv > d)
            return v;
        if (rem < d * tol_w || d < (tol_w <<< (2 * FRAC_W)))
            return v;
        v.hit = 1'b1;
        if (rem >= (d <<< Q_W))
            v.distance = DIST_MAX;
        else
            v.distance = Q_W'(rem / d);
        return v;
    endfunction

    task automatic report(input string what);
        $display("[%0t] result %0d: %s", $realtime, result_no, what);
        fail_count++;
    endtask

    assign outstanding = pending_verdicts.size();

    initial
    begin
        fail_count = 0;
        result_no = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_org = '{default: '0};
            ray_dir = '{32'd0, 32'd0, 32'h0001_0000};
            min_dist = 1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:    ray_org[0] = cfg_data;
                    REG_ORIGIN_Y:    ray_org[1] = cfg_data;
                    REG_ORIGIN_Z:    ray_org[2] = cfg_data;
                    REG_DIRECTION_X: ray_dir[0] = cfg_data;
                    REG_DIRECTION_Y: ray_dir[1] = cfg_data;
                    REG_DIRECTION_Z: ray_dir[2] = cfg_data;
                    REG_TOLERANCE:   min_dist = cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_verdicts.insert(pending_verdicts.size(),
                                        intersect_ray(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                verdict_t want;
                if (pending_verdicts.size() == 0)
                    report("unexpected result transaction");
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (m_axis_tuser !== want.hit)
                        report($sformatf("hit %b, expected %b", m_axis_tuser, want.hit));
                    if (m_axis_tdata[Q_W-1:0] !== want.distance)
                        report($sformatf("distance %h, expected %h",
                                         m_axis_tdata[Q_W-1:0], want.distance));
                end
                result_no++;
            end
        end
    end

endmodule

>>> verif/tb_ray_triangle_intersection.sv
// Testbench top for ray_triangle_intersection: drives ray settings and triangles,
// stalls both streams at random and gives the verdict. Depends on rti_pkg and rti_hit_checker.
`timescale 1ns / 1ps

module tb_ray_triangle_intersection;
    import rti_pkg::*;

    localparam int ONE = 1 << FRAC_W;         // 1.0 in Q16.16
    localparam int IDLE_LIMIT = 1000;         // cycles without any transaction
    localparam int DRAIN_CYCLES = 60;         // wait before the final verdict
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0] cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tuser;

    int fail_count;
    int outstanding;
    int idle_cycles;
    int stall_left;
    bit sender_gaps;
    bit receiver_stalls;

    // Current ray, mirrored here so aimed triangles can be placed on it.
    int ray_o [3];
    int ray_d [3];

    ray_triangle_intersection DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    rti_hit_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    always #6 clk = ~clk;

    // Receiver: while receiver_stalls is set, it may hold tready low after each accepted result.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready && receiver_stalls)
            stall_left = $urandom_range(0, 4);
    end

    // Watchdog: the run is stuck if no transaction of any kind moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_ray_triangle_intersection failed");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] make_triangle(input int x0, y0, z0,
                                                       input int x1, y1, z1,
                                                       input int x2, y2, z2);
        return {z2, y2, x2, z1, y1, x1, z0, y0, x0};
    endfunction

    function automatic int span(input int bits);
        return int'($urandom_range(0, 2 ** (bits + 1))) - 2 ** bits;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_ray(input int ox, oy, oz, input int dx, dy, dz, input int tol);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIRECTION_X, dx);
        write_reg(REG_DIRECTION_Y, dy);
        write_reg(REG_DIRECTION_Z, dz);
        write_reg(REG_TOLERANCE, tol);
        ray_o = '{ox, oy, oz};
        ray_d = '{dx, dy, dz};
    endtask

    // One triangle transaction; tvalid stays high straight into the next one
    // unless a gap is drawn.
    task automatic send_triangle(input logic [IN_W-1:0] tri_bits);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= tri_bits;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = sender_gaps ? $urandom_range(0, 4) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly triangles built around a point on the ray, so hits, edge cases and
    // near misses all occur; the rest is raw noise over every bit.
    task automatic random_triangle();
        int sc, s, px, py, pz;
        logic [IN_W-1:0] bits;
        if ($urandom_range(0, 9) < 7)
        begin
            sc = $urandom_range(2, 22);
            s = $urandom_range(0, 8);
            px = ray_o[0] + ray_d[0] * s + span(sc);
            py = ray_o[1] + ray_d[1] * s + span(sc);
            pz = ray_o[2] + ray_d[2] * s + span(sc);
            bits = make_triangle(px + span(sc), py + span(sc), pz + span(sc),
                                 px + span(sc), py + span(sc), pz + span(sc),
                                 px + span(sc), py + span(sc), pz + span(sc));
        end
        else
        begin
            for (int k = 0; k < 9; k++)
                bits[COORD_W*k +: COORD_W] = $urandom;
        end
        send_triangle(bits);
    endtask

    initial
    begin
        int kind;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        ray_o = '{0, 0, 0};
        ray_d = '{0, 0, ONE};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed triangles against the reset ray: origin zero, direction +z.
        send_triangle(make_triangle(-ONE, -ONE, 5*ONE, 3*ONE, -ONE, 5*ONE,
                                    -ONE, 3*ONE, 5*ONE));
        // Ray through the first vertex (u = v = 0).
        send_triangle(make_triangle(0, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE, 2*ONE));
        // Ray on the far edge, u + v exactly 1.
        send_triangle(make_triangle(ONE, ONE, 3*ONE, -ONE, ONE, 3*ONE,
                                    ONE, -ONE, 3*ONE));
        // Ray through the second vertex, u exactly 1.
        send_triangle(make_triangle(-ONE, 0, 2*ONE, 0, 0, 2*ONE, -ONE, ONE, 2*ONE));
        // Outside the triangle.
        send_triangle(make_triangle(5*ONE, 5*ONE, 3*ONE, 6*ONE, 5*ONE, 3*ONE,
                                    5*ONE, 6*ONE, 3*ONE));
        // Reversed winding gives a positive determinant.
        send_triangle(make_triangle(-ONE, -ONE, 5*ONE, -ONE, 3*ONE, 5*ONE,
                                    3*ONE, -ONE, 5*ONE));
        // Behind the origin.
        send_triangle(make_triangle(-ONE, -ONE, -5*ONE, 3*ONE, -ONE, -5*ONE,
                                    -ONE, 3*ONE, -5*ONE));
        // Plane parallel to the ray, and one tilted by a single LSB off a plane holding the ray (nearly parallel).
        send_triangle(make_triangle(ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE));
        send_triangle(make_triangle(-ONE, 0, 5*ONE, 3*ONE, 0, 5*ONE, -ONE, 1, 6*ONE));
        // Degenerate triangle.
        send_triangle(make_triangle(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        // Coordinate extremes.
        send_triangle({9{32'h8000_0000}});
        send_triangle({9{32'h7FFF_FFFF}});
        send_triangle(make_triangle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_triangle(make_triangle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
        drain();

        // Direction of one LSB makes the distance saturate; zero tolerance lets a
        // triangle through the origin hit at distance zero.
        set_ray(0, 0, 0, 0, 0, 1, 0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_triangle(make_triangle(-ONE, -ONE, ONE, 3*ONE, -ONE, ONE,
                                    -ONE, 3*ONE, ONE));
        send_triangle(make_triangle(-ONE, -ONE, 0, 3*ONE, -ONE, 0, -ONE, 3*ONE, 0));
        send_triangle(make_triangle(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        drain();
        set_ray(ONE, -ONE, 0, 0, 0, ONE, 2 * ONE);
        // Distance exactly at the tolerance, then just below it.
        send_triangle(make_triangle(0, -2*ONE, 2*ONE, 4*ONE, -2*ONE, 2*ONE,
                                    0, 2*ONE, 2*ONE));
        send_triangle(make_triangle(0, -2*ONE, 2*ONE-1, 4*ONE, -2*ONE, 2*ONE-1,
                                    0, 2*ONE-1, 2*ONE-1));
        drain();
        set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_triangle({9{32'h7FFF_FFFF}});
        send_triangle(make_triangle(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0));
        drain();

        // Random phases, each under its own ray setting and idling pattern.
        for (int phase = 0; phase < 8; phase++)
        begin
            kind = (phase < 5) ? phase : $urandom_range(0, 4);
            case (kind)
                0: set_ray(0, 0, 0, 0, 0, ONE, 1);
                1: set_ray(span(20), span(20), span(20), span(18), span(18), span(18),
                           $urandom_range(0, 1024));
                2: set_ray(span(20), span(20), span(20), 0, 0, 0, 0);
                3: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
                default: set_ray(span(16), span(16), span(16), span(17), span(17),
                                 span(17), 0);
            endcase
            sender_gaps = (phase % 3) != 1;
            receiver_stalls = (phase % 4) != 2;
            for (int n = 0; n < 105; n++)
            begin
                // Once, hold the stream until every result has come back.
                if (phase == 4 && n == 50)
                    drain();
                random_triangle();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_ray_triangle_intersection passed");
        else
            $display("tb_ray_triangle_intersection failed");
        $finish;
    end

endmodule
